// ===== rtl/core/gmf_pkg.sv =====
// ----------------------------------------------------------------------------
// gmf_pkg
// shared types, widths and codes for the gap midpoint filler
// ----------------------------------------------------------------------------
package gmf_pkg;

    // point store geometry
    localparam int MAX_POINTS = 32;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // field widths
    localparam int COORD_W    = 12;
    localparam int DIST_W     = 13;
    localparam int EXP_W      = 7;
    localparam int GAP_W      = 13;
    localparam int ADDED_W    = 7;

    // square root datapath widths
    localparam int SQ_W       = 2 * COORD_W;
    localparam int RAD_W      = SQ_W + 1;
    localparam int ROOT_W     = RAD_W + 1;
    localparam int BIT_W      = RAD_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPECTED  = 2'd0,
        REG_TOLERANCE = 2'd1,
        REG_MAX_GAP   = 2'd2
    } cfg_reg_t;

    localparam logic [GAP_W-1:0] MAX_GAP_RESET = {GAP_W{1'b1}};

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } point_t;

    // request to the distance unit
    typedef struct packed {
        logic   start;
        point_t a;
        point_t b;
    } dist_req_t;

    // answer from the distance unit
    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] gap_len;
    } dist_rsp_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_SQX,
        D_SQY,
        D_ROOT
    } dist_state_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_START,
        S_WAIT,
        S_CHECK,
        S_EMIT,
        S_TERM
    } seq_state_t;

endpackage

// ===== rtl/core/gmf_point_if.sv =====
// ----------------------------------------------------------------------------
// gmf_point_if
// input channel, one detected centre point per item
// ----------------------------------------------------------------------------
interface gmf_point_if import gmf_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

// ===== rtl/core/gmf_result_if.sv =====
// ----------------------------------------------------------------------------
// gmf_result_if
// output channel, one midpoint or terminator per item
// ----------------------------------------------------------------------------
interface gmf_result_if import gmf_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] mid_x;
    logic [COORD_W-1:0] mid_y;
    logic               has_point;
    logic               end_of_run;
    logic               overflowed;

    modport source (output valid, mid_x, mid_y, has_point, end_of_run, overflowed,
                    input ready);
    modport sink   (input valid, mid_x, mid_y, has_point, end_of_run, overflowed,
                    output ready);
endinterface

// ===== rtl/core/gmf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gmf_cfg_if
// configuration write channel, register index and write data
// ----------------------------------------------------------------------------
interface gmf_cfg_if import gmf_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/gmf_point_mem.sv =====
// ----------------------------------------------------------------------------
// gmf_point_mem
// point store, one write port and two registered read ports
// ----------------------------------------------------------------------------
module gmf_point_mem import gmf_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  point_t            wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output point_t            rdata_a,
    output point_t            rdata_b
);

    point_t mem_reg [MAX_POINTS];
    point_t rdata_a_reg;
    point_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/core/gmf_dist_unit.sv =====
// ----------------------------------------------------------------------------
// gmf_dist_unit
// floor of euclidean distance between two points, one shared multiplier
// and a two-bits-per-cycle integer square root
// ----------------------------------------------------------------------------
module gmf_dist_unit import gmf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dist_req_t req,
    output dist_rsp_t rsp
);

    dist_state_t        state_reg,  state_next;
    logic [COORD_W-1:0] dx_reg,     dx_next;
    logic [COORD_W-1:0] dy_reg,     dy_next;
    logic [SQ_W-1:0]    sq_reg,     sq_next;
    logic [RAD_W-1:0]   rad_reg,    rad_next;
    logic [ROOT_W-1:0]  root_reg,   root_next;
    logic [BIT_W-1:0]   bit_reg,    bit_next;
    logic               done_reg,   done_next;

    logic [COORD_W-1:0] mul_in;
    logic [SQ_W-1:0]    mul_out;
    logic [ROOT_W-1:0]  trial;

    // single shared squarer
    assign mul_in  = (state_reg == D_SQX) ? dx_reg : dy_reg;
    assign mul_out = mul_in * mul_in;
    assign trial   = root_reg + ROOT_W'(bit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        sq_reg   <= sq_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    always_comb
    begin
        state_next = state_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sq_next    = sq_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    dx_next = (req.a.x > req.b.x) ? req.a.x - req.b.x : req.b.x - req.a.x;
                    dy_next = (req.a.y > req.b.y) ? req.a.y - req.b.y : req.b.y - req.a.y;
                    state_next = D_SQX;
                end
            end
            D_SQX:
            begin
                sq_next    = mul_out;
                state_next = D_SQY;
            end
            D_SQY:
            begin
                rad_next   = RAD_W'(sq_reg) + RAD_W'(mul_out);
                root_next  = '0;
                bit_next   = BIT_W'(1) << (BIT_W - 1);
                state_next = D_ROOT;
            end
            D_ROOT:
            begin
                // one digit of the root per cycle
                if (ROOT_W'(rad_reg) >= trial)
                begin
                    rad_next  = rad_reg - RAD_W'(trial);
                    root_next = (root_reg >> 1) + ROOT_W'(bit_reg);
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    assign rsp.done    = done_reg;
    assign rsp.gap_len = root_reg[DIST_W-1:0];

endmodule

// ===== rtl/core/gap_midpoint_filler_top.sv =====
// ----------------------------------------------------------------------------
// gap_midpoint_filler_top
// collects a list of centre points and fills wide gaps with midpoints
// ----------------------------------------------------------------------------
// Points arrive one item per cycle on the points channel and are written to a
// 32-entry store; points beyond that are dropped and the run is flagged as
// overflowed. The item marked last_point closes the list and starts a run:
// with at least two points and fewer than expected_count, the block walks
// the neighbour pairs twice, first to find the smallest distance, then to
// emit the midpoint of each pair whose distance is above minimum plus
// gap_tolerance and below max_gap, until point count plus emitted midpoints
// reaches expected_count or the pairs run out. Every run ends with one empty
// terminator item (has_point 0, end_of_run 1). In the first pass each pair
// goes through a store read, start, two squarings on one multiplier,
// thirteen square-root steps and done; the second pass adds a count check
// per pair, and result items and any output stalls add to the run. While a
// run is in progress the points channel is not ready. Configuration writes
// are always accepted and should be made only between runs.
// ----------------------------------------------------------------------------
module gap_midpoint_filler_top import gmf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    gmf_point_if.sink    points,
    gmf_result_if.source results,
    gmf_cfg_if.sink      cfg
);

    // sequencer state and run registers
    seq_state_t          state_reg,    state_next;
    logic [CNT_W-1:0]    count_reg,    count_next;
    logic                ovf_reg,      ovf_next;
    logic [CNT_W-1:0]    n_reg,        n_next;
    logic [CNT_W-1:0]    idx_reg,      idx_next;
    logic [DIST_W-1:0]   min_reg,      min_next;
    logic [ADDED_W-1:0]  added_reg,    added_next;
    logic                pass_reg,     pass_next;
    logic [COORD_W-1:0]  out_x_reg,    out_x_next;
    logic [COORD_W-1:0]  out_y_reg,    out_y_next;

    // configuration registers
    logic [EXP_W-1:0]    expected_reg;
    logic [GAP_W-1:0]    tol_reg;
    logic [GAP_W-1:0]    max_gap_reg;

    // point store hookup
    logic                mem_we;
    point_t              mem_wdata;
    point_t              pt_cur;
    point_t              pt_prev;
    logic [CNT_W-1:0]    idx_prev;

    // distance unit hookup
    dist_req_t           dreq;
    dist_rsp_t           drsp;

    // combinational helpers
    logic                in_fire;
    logic                out_fire;
    logic                has_room;
    logic [CNT_W-1:0]    count_inc;
    logic [EXP_W:0]      total;
    logic [DIST_W:0]     thresh;
    logic                gap_hit;
    logic [CNT_W-1:0]    idx_inc;
    logic [COORD_W:0]    sum_x;
    logic [COORD_W:0]    sum_y;

    assign in_fire   = points.valid && points.ready;
    assign out_fire  = results.valid && results.ready;
    assign has_room  = (count_reg < CNT_W'(MAX_POINTS));
    assign count_inc = count_reg + CNT_W'(1);
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_prev  = idx_reg - CNT_W'(1);

    // points so far plus midpoints emitted in this run
    assign total     = (EXP_W + 1)'(n_reg) + (EXP_W + 1)'(added_reg);
    assign thresh    = (DIST_W + 1)'(min_reg) + (DIST_W + 1)'(tol_reg);
    assign gap_hit   = ((DIST_W + 1)'(drsp.gap_len) > thresh) &&
                       (drsp.gap_len < max_gap_reg);
    assign sum_x     = (COORD_W + 1)'(pt_cur.x) + (COORD_W + 1)'(pt_prev.x);
    assign sum_y     = (COORD_W + 1)'(pt_cur.y) + (COORD_W + 1)'(pt_prev.y);

    assign mem_we      = in_fire && has_room;
    assign mem_wdata.x = points.point_x;
    assign mem_wdata.y = points.point_y;

    gmf_point_mem u_mem
    (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (count_reg[ADDR_W-1:0]),
        .wdata   (mem_wdata),
        .raddr_a (idx_reg[ADDR_W-1:0]),
        .raddr_b (idx_prev[ADDR_W-1:0]),
        .rdata_a (pt_cur),
        .rdata_b (pt_prev)
    );

    assign dreq.start = (state_reg == S_START);
    assign dreq.a     = pt_cur;
    assign dreq.b     = pt_prev;

    gmf_dist_unit u_dist
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // configuration writes, unknown indexes ignored
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            tol_reg      <= '0;
            max_gap_reg  <= MAX_GAP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_EXPECTED:  expected_reg <= cfg.data[EXP_W-1:0];
                REG_TOLERANCE: tol_reg      <= cfg.data[GAP_W-1:0];
                REG_MAX_GAP:   max_gap_reg  <= cfg.data[GAP_W-1:0];
                default:       ;
            endcase
        end
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            n_reg     <= '0;
            idx_reg   <= '0;
            added_reg <= '0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
            added_reg <= added_next;
            pass_reg  <= pass_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        min_reg   <= min_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        min_next   = min_reg;
        added_next = added_reg;
        pass_next  = pass_reg;
        out_x_next = out_x_reg;
        out_y_next = out_y_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (has_room)
                    begin
                        count_next = count_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (points.last_point)
                    begin
                        n_next     = count_next;
                        idx_next   = CNT_W'(1);
                        added_next = '0;
                        pass_next  = 1'b0;
                        // a run needs a pair and a shortfall
                        if (count_next >= CNT_W'(2) &&
                            (EXP_W + 1)'(count_next) < (EXP_W + 1)'(expected_reg))
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            state_next = S_TERM;
                        end
                    end
                end
            end
            S_READ:
            begin
                // store read of the pair is in flight
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (drsp.done)
                begin
                    if (!pass_reg)
                    begin
                        // minimum search pass
                        if (idx_reg == CNT_W'(1) || drsp.gap_len < min_reg)
                        begin
                            min_next = drsp.gap_len;
                        end
                        if (idx_inc < n_reg)
                        begin
                            idx_next   = idx_inc;
                            state_next = S_READ;
                        end
                        else
                        begin
                            idx_next   = CNT_W'(1);
                            pass_next  = 1'b1;
                            state_next = S_CHECK;
                        end
                    end
                    else if (gap_hit)
                    begin
                        out_x_next = sum_x[COORD_W:1];
                        out_y_next = sum_y[COORD_W:1];
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = (idx_inc < n_reg) ? S_CHECK : S_TERM;
                    end
                end
            end
            S_CHECK:
            begin
                // stop once the expected total is reached
                if (total >= (EXP_W + 1)'(expected_reg))
                begin
                    state_next = S_TERM;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_EMIT:
            begin
                if (out_fire)
                begin
                    added_next = added_reg + ADDED_W'(1);
                    idx_next   = idx_inc;
                    state_next = (idx_inc < n_reg) ? S_CHECK : S_TERM;
                end
            end
            S_TERM:
            begin
                if (out_fire)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // channel outputs
    assign points.ready = (state_reg == S_LOAD);

    assign results.valid      = (state_reg == S_EMIT) || (state_reg == S_TERM);
    assign results.has_point  = (state_reg == S_EMIT);
    assign results.end_of_run = (state_reg == S_TERM);
    assign results.mid_x      = (state_reg == S_EMIT) ? out_x_reg : '0;
    assign results.mid_y      = (state_reg == S_EMIT) ? out_y_reg : '0;
    assign results.overflowed = ovf_reg;

endmodule
